[rtl/core/kps_pkg.sv]
// ----------------------------------------------------------------------------
// kps_pkg: shared types and constants for the 4x4 keypad scanner
// Phase codes, register indexes, configuration record and the key table.
// ----------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

   // Widths
   localparam int unsigned LINE_W  = 4;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned ROW_W   = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SETTLE   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_REL1     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_GAP      = 3'd4;
   localparam logic [PHASE_W-1:0] PH_REL2     = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAP       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRANSPOSE = 2'd3;

   // Reset values
   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd1000;
   localparam logic [TICK_W-1:0] SETTLE_RESET   = 16'd100;
   localparam logic [TICK_W-1:0] GAP_RESET      = 16'd5;

   // All lines released
   localparam logic [LINE_W-1:0] LINES_HIGH = 4'hF;

   typedef struct packed {
      logic [TICK_W-1:0] debounce_ticks;
      logic [TICK_W-1:0] settle_ticks;
      logic [TICK_W-1:0] release_gap_ticks;
      logic              transpose_layout;
   } cfg_type;

   typedef struct packed {
      logic              drive_rows;
      logic              key_valid;
      logic [CODE_W-1:0] key_code;
   } result_type;

   // Key table, index row*4+col: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
   function automatic logic [CODE_W-1:0] key_lookup(input logic [3:0] idx);
      logic [CODE_W-1:0] code;
      case (idx)
         4'd0:    code = 4'd1;
         4'd1:    code = 4'd2;
         4'd2:    code = 4'd3;
         4'd3:    code = 4'd10;
         4'd4:    code = 4'd4;
         4'd5:    code = 4'd5;
         4'd6:    code = 4'd6;
         4'd7:    code = 4'd11;
         4'd8:    code = 4'd7;
         4'd9:    code = 4'd8;
         4'd10:   code = 4'd9;
         4'd11:   code = 4'd12;
         4'd12:   code = 4'd13;
         4'd13:   code = 4'd0;
         4'd14:   code = 4'd14;
         default: code = 4'd15;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[rtl/core/kps_req_if.sv]
// ----------------------------------------------------------------------------
// kps_req_if: sampled pin word channel
// Valid/ready channel carrying one tick of row and column levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface kps_req_if;
   logic                       valid;
   logic                       ready;
   logic [kps_pkg::LINE_W-1:0] row_levels;
   logic [kps_pkg::LINE_W-1:0] col_levels;

   modport source (output valid, output row_levels, output col_levels, input ready);
   modport sink   (input valid, input row_levels, input col_levels, output ready);
endinterface

`default_nettype wire

[rtl/core/kps_rsp_if.sv]
// ----------------------------------------------------------------------------
// kps_rsp_if: scan result word channel
// Valid/ready channel carrying drive select and key report for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface kps_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       drive_rows;
   logic                       key_valid;
   logic [kps_pkg::CODE_W-1:0] key_code;

   modport source (output valid, output drive_rows, output key_valid, output key_code,
                   input ready);
   modport sink   (input valid, input drive_rows, input key_valid, input key_code,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/kps_csr.sv]
// ----------------------------------------------------------------------------
// kps_csr: configuration registers
// Holds the three wait limits and the layout select, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [kps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [kps_pkg::CSR_DATA_W-1:0] csr_wdata,
   output kps_pkg::cfg_type                   cfg
);

   kps_pkg::cfg_type cfg_ff;
   kps_pkg::cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            kps_pkg::REG_DEBOUNCE:  cfg_in.debounce_ticks    = csr_wdata;
            kps_pkg::REG_SETTLE:    cfg_in.settle_ticks      = csr_wdata;
            kps_pkg::REG_GAP:       cfg_in.release_gap_ticks = csr_wdata;
            kps_pkg::REG_TRANSPOSE: cfg_in.transpose_layout  = csr_wdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks    <= kps_pkg::DEBOUNCE_RESET;
         cfg_ff.settle_ticks      <= kps_pkg::SETTLE_RESET;
         cfg_ff.release_gap_ticks <= kps_pkg::GAP_RESET;
         cfg_ff.transpose_layout  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/kps_scan.sv]
// ----------------------------------------------------------------------------
// kps_scan: scan sequencer
// Phase, tick counter and latched row; steps once per word and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [kps_pkg::LINE_W-1:0]  row_levels,
   input  wire logic [kps_pkg::LINE_W-1:0]  col_levels,
   input  wire kps_pkg::cfg_type            cfg,
   output kps_pkg::result_type              result
);

   logic [kps_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [kps_pkg::TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [kps_pkg::ROW_W-1:0]   row_index_ff, row_index_in;

   logic [kps_pkg::TICK_W-1:0]  limit;
   logic                        wait_done;
   logic                        row_hit, col_hit;
   logic [kps_pkg::ROW_W-1:0]   row_first, col_first;
   logic [3:0]                  key_idx;
   logic                        valid;
   logic [kps_pkg::CODE_W-1:0]  code;

   // Lowest low row / column
   always_comb begin
      row_hit   = (row_levels != kps_pkg::LINES_HIGH);
      row_first = 2'd3;
      if (!row_levels[2]) row_first = 2'd2;
      if (!row_levels[1]) row_first = 2'd1;
      if (!row_levels[0]) row_first = 2'd0;
      col_hit   = (col_levels != kps_pkg::LINES_HIGH);
      col_first = 2'd3;
      if (!col_levels[2]) col_first = 2'd2;
      if (!col_levels[1]) col_first = 2'd1;
      if (!col_levels[0]) col_first = 2'd0;
   end

   // Limit of the wait in progress
   always_comb begin
      case (phase_ff)
         kps_pkg::PH_DEBOUNCE: limit = cfg.debounce_ticks;
         kps_pkg::PH_SETTLE:   limit = cfg.settle_ticks;
         default:              limit = cfg.release_gap_ticks;
      endcase
      wait_done = (tick_count_ff >= limit);
   end

   // Key index, transposed on request
   assign key_idx = cfg.transpose_layout ? {col_first, row_index_ff} : {row_index_ff, col_first};

   // Next phase
   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      row_index_in  = row_index_ff;
      valid         = 1'b0;
      code          = '0;
      case (phase_ff)
         kps_pkg::PH_DEBOUNCE: begin
            if (wait_done) begin
               if (row_hit) begin
                  row_index_in = row_first;
                  phase_in     = kps_pkg::PH_SETTLE;
               end else begin
                  phase_in = kps_pkg::PH_IDLE;
               end
               tick_count_in = '0;
            end else begin
               tick_count_in = tick_count_ff + 16'd1;
            end
         end
         kps_pkg::PH_SETTLE: begin
            if (wait_done) begin
               if (col_hit) begin
                  valid = 1'b1;
                  code  = kps_pkg::key_lookup(key_idx);
               end
               phase_in      = kps_pkg::PH_REL1;
               tick_count_in = '0;
            end else begin
               tick_count_in = tick_count_ff + 16'd1;
            end
         end
         kps_pkg::PH_REL1: begin
            if (!col_hit) begin
               phase_in      = kps_pkg::PH_GAP;
               tick_count_in = '0;
            end
         end
         kps_pkg::PH_GAP: begin
            if (wait_done) begin
               phase_in      = kps_pkg::PH_REL2;
               tick_count_in = '0;
            end else begin
               tick_count_in = tick_count_ff + 16'd1;
            end
         end
         kps_pkg::PH_REL2: begin
            if (!col_hit) begin
               phase_in      = kps_pkg::PH_IDLE;
               tick_count_in = '0;
            end
         end
         default: begin
            phase_in      = row_hit ? kps_pkg::PH_DEBOUNCE : kps_pkg::PH_IDLE;
            tick_count_in = '0;
         end
      endcase
   end

   // Result of this word; rows driven in settle through second release check
   always_comb begin
      result.drive_rows = (phase_in >= kps_pkg::PH_SETTLE) && (phase_in <= kps_pkg::PH_REL2);
      result.key_valid  = valid;
      result.key_code   = code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= kps_pkg::PH_IDLE;
         tick_count_ff <= '0;
         row_index_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         row_index_ff  <= row_index_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/matrix_keypad_scanner_core.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core: 4x4 keypad scanner, one tick per word
// Input register, scan sequencer and result register with config registers.
// ----------------------------------------------------------------------------
//  Port   Dir  Handshake       Payload
//  req    in   valid/ready     row_levels[3:0], col_levels[3:0]
//  rsp    out  valid/ready     drive_rows, key_valid, key_code[3:0]
//  csr_*  in   write enable    csr_index[1:0], csr_wdata[15:0]
//
//  One word is taken per cycle while rsp does not stall; its result is presented on
//  rsp after it passes the input register and then the result register.
//  The sequencer state advances only when a word moves from the input register
//  to the result register, so stalls on rsp hold everything in place.
//  Synchronous reset returns to idle with columns driven and default limits.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_scanner_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   kps_req_if.sink                             req,
   kps_rsp_if.source                           rsp,
   input  wire logic                           csr_we,
   input  wire logic [kps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kps_pkg::CSR_DATA_W-1:0] csr_wdata
);

   kps_pkg::cfg_type    cfg;
   kps_pkg::result_type result;

   logic                       in_valid_ff;
   logic [kps_pkg::LINE_W-1:0] in_rows_ff;
   logic [kps_pkg::LINE_W-1:0] in_cols_ff;
   logic                       out_valid_ff;
   kps_pkg::result_type        out_ff;

   logic out_free;
   logic advance;
   logic take;

   // Pipeline flow
   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign take      = req.valid && req.ready;

   kps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kps_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .row_levels (in_rows_ff),
      .col_levels (in_cols_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_rows_ff <= req.row_levels;
         in_cols_ff <= req.col_levels;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.drive_rows = out_ff.drive_rows;
   assign rsp.key_valid  = out_ff.key_valid;
   assign rsp.key_code   = out_ff.key_code;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for matrix_keypad_scanner_core
// Walks a directed table of pin words and register writes, then random key
// presses, bounce and line noise under random stalls on both channels. Every
// result word is checked against a cycle-free scan predictor.
// ----------------------------------------------------------------------------
module testbench;
   import kps_pkg::*;

   // Two register stages between acceptance and result
   localparam int unsigned LATENCY = 2;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned WORDS_PER_PHASE = 170;
   localparam int unsigned LONG_HOLD = 80;

   // Key codes by index row*4+col
   localparam logic [CODE_W-1:0] KEY_MAP [16] = '{
      4'd1,  4'd2, 4'd3,  4'd10,
      4'd4,  4'd5, 4'd6,  4'd11,
      4'd7,  4'd8, 4'd9,  4'd12,
      4'd13, 4'd0, 4'd14, 4'd15
   };

   // Directed table: pin words and register writes
   typedef enum logic {DIR_WORD, DIR_CSR} plan_kind_type;

   typedef struct packed {
      plan_kind_type         kind;
      logic [LINE_W-1:0]     rows;
      logic [LINE_W-1:0]     cols;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  typed;
      logic                  drive;
      logic                  valid;
      logic [CODE_W-1:0]     code;
   } plan_row_type;

   localparam int unsigned PLAN_LEN = 40;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // after reset: idle, then a press under the default debounce
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b1, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hE, 4'hF, REG_DEBOUNCE,  16'd0,     1'b1, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b1, 1'b0, 1'b0, 4'd0},
      // debounce lowered below the running count ends the wait at once
      '{DIR_CSR,  4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'h0, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_CSR,  4'hF, 4'hF, REG_SETTLE,    16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      // all columns low: column 0 wins, key 1
      '{DIR_WORD, 4'hF, 4'h0, REG_DEBOUNCE,  16'd0,     1'b1, 1'b1, 1'b1, 4'd1},
      '{DIR_WORD, 4'hF, 4'hE, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'h0, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_CSR,  4'hF, 4'hF, REG_GAP,       16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'h0, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'h7, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      // transposed layout, limits at their top value then cut short
      '{DIR_CSR,  4'hF, 4'hF, REG_TRANSPOSE, 16'd1,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'h7, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_CSR,  4'hF, 4'hF, REG_DEBOUNCE,  16'hFFFF,  1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_CSR,  4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'h7, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_CSR,  4'hF, 4'hF, REG_SETTLE,    16'hFFFF,  1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'h7, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_CSR,  4'hF, 4'hF, REG_SETTLE,    16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      // row 3, column 3: key D
      '{DIR_WORD, 4'hF, 4'h7, REG_DEBOUNCE,  16'd0,     1'b1, 1'b1, 1'b1, 4'd15},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_CSR,  4'hF, 4'hF, REG_GAP,       16'hFFFF,  1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_CSR,  4'hF, 4'hF, REG_GAP,       16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      // row gone at confirmation: back to idle, no key
      '{DIR_WORD, 4'h0, 4'h0, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b1, 1'b0, 1'b0, 4'd0},
      // column gone after settling: no key, release waits still run
      '{DIR_WORD, 4'hB, 4'h5, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hB, 4'h5, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b1, 1'b1, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hF, 4'hF, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      // asymmetric key under transposition
      '{DIR_WORD, 4'hD, 4'h3, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'hD, 4'h3, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
      '{DIR_WORD, 4'h0, 4'hB, REG_DEBOUNCE,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0}
   };

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   kps_req_if req_ch ();
   kps_rsp_if rsp_ch ();

   matrix_keypad_scanner_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Scanner shadow state
   cfg_type           scan_cfg;
   logic [PHASE_W-1:0] scan_phase;
   logic [TICK_W-1:0]  scan_ticks;
   logic [ROW_W-1:0]   scan_row;

   result_type  pending_reports [$];
   int unsigned mismatches = 0;
   int unsigned words_sent = 0;
   bit          tx_burst = 1'b0;
   bit          rx_burst = 1'b0;
   bit          tx_force_burst = 1'b0;
   bit          long_hold_due = 1'b0;

   // Lowest low line, 4 when all lines are high
   function automatic logic [2:0] lowest_low(input logic [LINE_W-1:0] levels);
      logic [2:0] pos;
      pos = 3'd4;
      for (int i = LINE_W - 1; i >= 0; i--) begin
         if (!levels[i]) pos = 3'(i);
      end
      return pos;
   endfunction

   // True once the count reaches the limit, else counts one tick
   function automatic bit wait_over(input logic [TICK_W-1:0] limit);
      if (scan_ticks >= limit) return 1'b1;
      scan_ticks = scan_ticks + 16'd1;
      return 1'b0;
   endfunction

   // One tick of the scan sequence
   function automatic result_type scan_tick(input logic [LINE_W-1:0] rows,
                                            input logic [LINE_W-1:0] cols);
      result_type rep;
      logic [2:0] r;
      logic [2:0] c;
      logic [3:0] idx;
      rep = '0;
      case (scan_phase)
         PH_DEBOUNCE: begin
            if (wait_over(scan_cfg.debounce_ticks)) begin
               r = lowest_low(rows);
               if (r < 3'd4) begin
                  scan_row   = r[1:0];
                  scan_phase = PH_SETTLE;
               end else begin
                  scan_phase = PH_IDLE;
               end
               scan_ticks = '0;
            end
         end
         PH_SETTLE: begin
            if (wait_over(scan_cfg.settle_ticks)) begin
               c = lowest_low(cols);
               if (c < 3'd4) begin
                  idx = scan_cfg.transpose_layout ? {c[1:0], scan_row} : {scan_row, c[1:0]};
                  rep.key_code  = KEY_MAP[idx];
                  rep.key_valid = 1'b1;
               end
               scan_phase = PH_REL1;
               scan_ticks = '0;
            end
         end
         PH_REL1: begin
            if (cols == LINES_HIGH) begin
               scan_phase = PH_GAP;
               scan_ticks = '0;
            end
         end
         PH_GAP: begin
            if (wait_over(scan_cfg.release_gap_ticks)) begin
               scan_phase = PH_REL2;
               scan_ticks = '0;
            end
         end
         PH_REL2: begin
            if (cols == LINES_HIGH) begin
               scan_phase = PH_IDLE;
               scan_ticks = '0;
            end
         end
         default: begin
            // idle, and any stray phase code
            scan_phase = (rows != LINES_HIGH) ? PH_DEBOUNCE : PH_IDLE;
            scan_ticks = '0;
         end
      endcase
      rep.drive_rows = (scan_phase >= PH_SETTLE && scan_phase <= PH_REL2);
      return rep;
   endfunction

   // Offer one pin word, predict its report once accepted
   task automatic send_word(input logic [LINE_W-1:0] rows, input logic [LINE_W-1:0] cols,
                            input logic typed, input result_type typed_rep);
      int unsigned gap;
      result_type  rep;
      if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
      gap = (tx_burst || tx_force_burst) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.row_levels <= rows;
      req_ch.col_levels <= cols;
      do @(posedge clock); while (!req_ch.ready);
      rep = scan_tick(rows, cols);
      pending_reports.push_back(typed ? typed_rep : rep);
      words_sent++;
   endtask

   // Stop offering and wait for every outstanding report
   task automatic wait_reports_drained();
      req_ch.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // Register write; caller lowers csr_we after the last one
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_DEBOUNCE:  scan_cfg.debounce_ticks    = data;
         REG_SETTLE:    scan_cfg.settle_ticks      = data;
         REG_GAP:       scan_cfg.release_gap_ticks = data;
         REG_TRANSPOSE: scan_cfg.transpose_layout  = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Mostly short waits, sometimes zero, the top value or anything
   function automatic logic [TICK_W-1:0] pick_limit();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 16'hFFFF;
      if (sel == 1) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 6));
   endfunction

   // Stimulus
   initial begin
      int unsigned  phase_start;
      int unsigned  base;
      int unsigned  hold_len;
      int unsigned  n;
      bit           paused;
      logic [LINE_W-1:0] row_pat;
      logic [LINE_W-1:0] col_pat;
      result_type   typed_rep;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= REG_DEBOUNCE;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.row_levels <= LINES_HIGH;
      req_ch.col_levels <= LINES_HIGH;
      scan_cfg.debounce_ticks    = DEBOUNCE_RESET;
      scan_cfg.settle_ticks      = SETTLE_RESET;
      scan_cfg.release_gap_ticks = GAP_RESET;
      scan_cfg.transpose_layout  = 1'b0;
      scan_phase = PH_IDLE;
      scan_ticks = '0;
      scan_row   = '0;
      paused     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (PLAN[i]) begin
         if (PLAN[i].kind == DIR_CSR) begin
            wait_reports_drained();
            repeat (LATENCY + 2) @(posedge clock);
            write_csr(PLAN[i].idx, PLAN[i].data);
            csr_we <= 1'b0;
         end else begin
            typed_rep.drive_rows = PLAN[i].drive;
            typed_rep.key_valid  = PLAN[i].valid;
            typed_rep.key_code   = PLAN[i].code;
            send_word(PLAN[i].rows, PLAN[i].cols, PLAN[i].typed, typed_rep);
         end
      end

      // Random phases, each under fresh limits
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_reports_drained();
         repeat (LATENCY + 2) @(posedge clock);
         if (ph == 0) begin
            write_csr(REG_DEBOUNCE, 16'd0);
            write_csr(REG_SETTLE, 16'd0);
            write_csr(REG_GAP, 16'd0);
            write_csr(REG_TRANSPOSE, 16'd0);
         end else begin
            write_csr(REG_DEBOUNCE, pick_limit());
            write_csr(REG_SETTLE, pick_limit());
            write_csr(REG_GAP, pick_limit());
            write_csr(REG_TRANSPOSE, 16'($urandom_range(0, 1)));
         end
         csr_we <= 1'b0;
         if (ph == 2) begin
            // receiver holds off while words keep coming
            long_hold_due  = 1'b1;
            tx_force_burst = 1'b1;
         end
         phase_start = words_sent;
         while (words_sent - phase_start < WORDS_PER_PHASE) begin
            if (ph == 4 && !paused && words_sent - phase_start >= WORDS_PER_PHASE / 2) begin
               wait_reports_drained();
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
               // key press: lead-in, held lines with bounce, release
               row_pat = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 14))
                                                    : ~(4'b1 << $urandom_range(0, 3));
               if ($urandom_range(0, 9) == 0) col_pat = LINES_HIGH;
               else if ($urandom_range(0, 3) == 0) col_pat = 4'($urandom_range(0, 14));
               else col_pat = ~(4'b1 << $urandom_range(0, 3));
               base = int'(scan_cfg.debounce_ticks) + int'(scan_cfg.settle_ticks) + 3;
               if (base > 40) base = 40;
               hold_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, base)
                                                     : base + $urandom_range(0, 4);
               n = $urandom_range(0, 3);
               repeat (n) send_word(LINES_HIGH, LINES_HIGH, 1'b0, '0);
               repeat (hold_len) begin
                  if ($urandom_range(0, 9) == 0)
                     send_word(4'($urandom), 4'($urandom), 1'b0, '0);
                  else
                     send_word(row_pat, col_pat, 1'b0, '0);
               end
               n = (scan_cfg.release_gap_ticks > 20) ? 20 : int'(scan_cfg.release_gap_ticks);
               n = n + $urandom_range(0, 6);
               repeat (n) begin
                  if ($urandom_range(0, 7) == 0)
                     send_word(LINES_HIGH, 4'($urandom), 1'b0, '0);
                  else
                     send_word(LINES_HIGH, LINES_HIGH, 1'b0, '0);
               end
            end else begin
               // line noise
               n = $urandom_range(1, 6);
               repeat (n) send_word(4'($urandom), 4'($urandom), 1'b0, '0);
            end
         end
         tx_force_burst = 1'b0;
      end

      // Drain and let the pipeline run dry
      wait_reports_drained();
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Result side ready with random stalls and one long hold
   initial begin
      int unsigned n;
      rsp_ch.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
         n = rx_burst ? 0 : $urandom_range(0, 12);
         if (long_hold_due) begin
            n = LONG_HOLD;
            long_hold_due = 1'b0;
         end
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : report_check
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result word drive_rows=%0b key_valid=%0b key_code=%0d",
                     $time, rsp_ch.drive_rows, rsp_ch.key_valid, rsp_ch.key_code);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_ch.drive_rows !== want.drive_rows) begin
               $display("%0t: drive_rows mismatch, expected %0b, got %0b",
                        $time, want.drive_rows, rsp_ch.drive_rows);
               mismatches++;
            end
            if (rsp_ch.key_valid !== want.key_valid) begin
               $display("%0t: key_valid mismatch, expected %0b, got %0b",
                        $time, want.key_valid, rsp_ch.key_valid);
               mismatches++;
            end
            if (rsp_ch.key_code !== want.key_code) begin
               $display("%0t: key_code mismatch, expected %0d, got %0d",
                        $time, want.key_code, rsp_ch.key_code);
               mismatches++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/kps_pkg.sv
rtl/core/kps_req_if.sv
rtl/core/kps_rsp_if.sv
rtl/core/kps_csr.sv
rtl/core/kps_scan.sv
rtl/core/matrix_keypad_scanner_core.sv
tb/sv/testbench.sv
